// ===== design/bmh_pkg.sv =====
package bmh_pkg;

  localparam int NUM_BINS = 512;
  localparam int BIN_AW   = $clog2(NUM_BINS);
  localparam int DIV_W    = 112;
  localparam int CNT_W    = 7;

  localparam logic [1:0] CFG_BIN_WIDTH = 2'd0;
  localparam logic [1:0] CFG_BINS_USED = 2'd1;
  localparam logic [1:0] CFG_TOTAL     = 2'd2;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [23:0] volume;
    logic [15:0] perimeter;
    logic [15:0] gyration_radius;
    logic [8:0]  read_bin;
  } bmh_in_t;

  typedef struct packed {
    logic [33:0] bin_center;
    logic [31:0] hits;
    logic        occupied;
    logic [23:0] mean_perimeter;
    logic [23:0] perimeter_error;
    logic [23:0] mean_radius;
    logic [23:0] radius_error;
    logic [16:0] fraction;
    logic [16:0] fraction_error;
    logic [31:0] overflow_count;
  } bmh_out_t;

  typedef struct packed {
    logic [31:0] hits;
    logic [47:0] psum;
    logic [63:0] psq;
    logic [47:0] rsum;
    logic [63:0] rsq;
  } bmh_bin_t;

  typedef struct packed {
    logic              rd;
    logic              acc;
    logic [BIN_AW-1:0] addr;
    logic [15:0]       per;
    logic [15:0]       rad;
  } bmh_store_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BIN_DIV,
    S_BIN_APPLY,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_MEAN_DIV,
    S_MEAN_DONE,
    S_MUL,
    S_MUL_ACC,
    S_VAR_CHECK,
    S_ERR_DIV,
    S_SQRT_CHECK,
    S_SQRT,
    S_SQRT_DONE,
    S_NEXT,
    S_FR_DIV,
    S_FR_DONE,
    S_DONE
  } bmh_state_t;

  typedef enum logic [1:0] {
    PH_PER,
    PH_RAD,
    PH_FRAC
  } bmh_phase_t;

endpackage

// ===== design/bmh_bin_store.sv =====
module bmh_bin_store (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bmh_pkg::bmh_store_req_t req,
  output bmh_pkg::bmh_bin_t       rdata,
  output logic                    busy
);

  bmh_pkg::bmh_bin_t mem [bmh_pkg::NUM_BINS];
  bmh_pkg::bmh_bin_t rdata_r;
  bmh_pkg::bmh_bin_t upd;
  bmh_pkg::bmh_bin_t wdata;

  logic                       clr_active_r;
  logic [bmh_pkg::BIN_AW-1:0] clr_addr_r;
  logic                       pend_r;
  logic [bmh_pkg::BIN_AW-1:0] pend_addr_r;
  logic [15:0]                per_r;
  logic [15:0]                rad_r;

  logic                       we;
  logic [bmh_pkg::BIN_AW-1:0] waddr;
  logic [31:0]                sq_p;
  logic [31:0]                sq_r;
  logic [32:0]                hit_sum;
  logic [48:0]                ps_sum;
  logic [64:0]                pq_sum;
  logic [48:0]                rs_sum;
  logic [64:0]                rq_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      pend_r       <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == bmh_pkg::BIN_AW'(bmh_pkg::NUM_BINS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      pend_r <= req.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (req.acc) begin
      pend_addr_r <= req.addr;
      per_r       <= req.per;
      rad_r       <= req.rad;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd || req.acc) begin
      rdata_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    sq_p     = 32'(per_r) * 32'(per_r);
    sq_r     = 32'(rad_r) * 32'(rad_r);
    hit_sum  = {1'b0, rdata_r.hits} + 33'd1;
    ps_sum   = {1'b0, rdata_r.psum} + 49'(per_r);
    pq_sum   = {1'b0, rdata_r.psq} + 65'(sq_p);
    rs_sum   = {1'b0, rdata_r.rsum} + 49'(rad_r);
    rq_sum   = {1'b0, rdata_r.rsq} + 65'(sq_r);
    upd.hits = hit_sum[32] ? '1 : hit_sum[31:0];
    upd.psum = ps_sum[48] ? '1 : ps_sum[47:0];
    upd.psq  = pq_sum[64] ? '1 : pq_sum[63:0];
    upd.rsum = rs_sum[48] ? '1 : rs_sum[47:0];
    upd.rsq  = rq_sum[64] ? '1 : rq_sum[63:0];
    we       = clr_active_r || pend_r;
    waddr    = clr_active_r ? clr_addr_r : pend_addr_r;
    wdata    = clr_active_r ? '0 : upd;
  end

  assign rdata = rdata_r;
  assign busy  = clr_active_r || pend_r;

endmodule

// ===== design/binned_moment_histogram_top.sv =====
// Histogram with per-bin moments. For an accumulate item a restoring
// divider finds volume / bin_width one quotient bit per cycle, then
// the bin's sums are updated by a read-modify-write of the bin store.
// A read item runs all on one shared bit-serial divider and square-root
// step under a sequencer: for each of the perimeter and the radius a
// 56-step mean division, six 32x32 partial products for the variance,
// three 112-step divisions by the hit count and a 24-step root; then the
// fraction division (48 steps) and its error (three 112-step divisions
// and a root). Empty bins and nonpositive variances skip the matching
// work. After reset the bin store clears all NUM_BINS (512) bins, during
// which no item is accepted; configuration writes are taken at any time.
// A finished result waits in an output register while the next item is
// accepted.
module binned_moment_histogram_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bmh_pkg::bmh_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bmh_pkg::bmh_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int DW = bmh_pkg::DIV_W;

  bmh_pkg::bmh_state_t     state_r, state_nxt;
  bmh_pkg::bmh_phase_t     phase_r;
  bmh_pkg::bmh_in_t        item_r;
  bmh_pkg::bmh_store_req_t store_req;
  bmh_pkg::bmh_bin_t       rdata;
  logic                    store_busy;

  logic [23:0]       bin_width_r;
  logic [9:0]        bins_used_r;
  logic [31:0]       total_r;
  logic [31:0]       ovf_r;

  logic [DW-1:0]     w_r;
  logic [31:0]       r_r;
  logic [31:0]       d_r;
  logic [23:0]       root_r;
  logic [bmh_pkg::CNT_W-1:0] cnt_r;
  logic [1:0]        pass_r;
  logic [2:0]        idx_r;
  logic [63:0]       pp_r;
  logic              pp_sub_r;
  logic [1:0]        pp_sh_r;
  logic              pp_last_r;
  logic signed [97:0] acc_r;
  logic [31:0]       hits_r;
  logic [33:0]       bc_r;
  logic [23:0]       mp_r, ep_r, mr_r, er_r;
  logic [16:0]       fr_r, fe_r;
  logic              out_valid_r;
  bmh_pkg::bmh_out_t out_data_r;

  logic              in_fire;
  logic              out_free;
  logic [23:0]       width_eff;
  logic              bin_hit;
  logic              in_range;
  logic [31:0]       rd_hits;
  logic [31:0]       h_val;
  logic [47:0]       sel_s;
  logic [63:0]       sel_q;
  logic [32:0]       div_sh;
  logic [32:0]       div_diff;
  logic              div_ge;
  logic [31:0]       div_rem;
  logic [26:0]       sq_sh;
  logic [26:0]       sq_trial;
  logic              sq_ge;
  logic [26:0]       sq_rem;
  logic [31:0]       op_a, op_b;
  logic              op_sub;
  logic [1:0]        op_sh;
  logic              op_last;
  logic [97:0]       addend;
  logic              acc_pos;
  logic [23:0]       mean_sat;
  logic              err_we;
  logic [23:0]       err_val;

  bmh_bin_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (store_req),
    .rdata (rdata),
    .busy  (store_busy)
  );

  always_comb begin
    in_fire   = in_valid && in_ready;
    out_free  = !out_valid_r || out_ready;
    width_eff = (bin_width_r == 24'd0) ? 24'd1 : bin_width_r;
    bin_hit   = (w_r[23:0] < {14'd0, bins_used_r}) &&
                (32'(w_r[23:0]) < bmh_pkg::NUM_BINS);
    in_range  = 32'(item_r.read_bin) < bmh_pkg::NUM_BINS;
    rd_hits   = in_range ? rdata.hits : 32'd0;
    h_val     = (hits_r > total_r) ? total_r : hits_r;
    sel_s     = (phase_r == bmh_pkg::PH_RAD) ? rdata.rsum : rdata.psum;
    sel_q     = (phase_r == bmh_pkg::PH_RAD) ? rdata.rsq : rdata.psq;

    div_sh   = {r_r, w_r[DW-1]};
    div_diff = div_sh - {1'b0, d_r};
    div_ge   = div_sh >= {1'b0, d_r};
    div_rem  = div_ge ? div_diff[31:0] : div_sh[31:0];

    sq_sh    = {r_r[24:0], w_r[47:46]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_rem   = sq_ge ? (sq_sh - sq_trial) : sq_sh;

    acc_pos  = !acc_r[97] && (acc_r != '0);
    mean_sat = (|w_r[55:24]) ? 24'hFFFFFF : w_r[23:0];
  end

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_sub  = 1'b0;
    op_sh   = 2'd0;
    op_last = 1'b0;
    if (phase_r == bmh_pkg::PH_FRAC) begin
      op_a    = h_val;
      op_b    = total_r - h_val;
      op_last = 1'b1;
    end else begin
      unique case (idx_r)
        3'd0: begin
          op_a = hits_r;
          op_b = sel_q[31:0];
        end
        3'd1: begin
          op_a  = hits_r;
          op_b  = sel_q[63:32];
          op_sh = 2'd1;
        end
        3'd2: begin
          op_a   = sel_s[31:0];
          op_b   = sel_s[31:0];
          op_sub = 1'b1;
        end
        3'd3, 3'd4: begin
          op_a   = sel_s[31:0];
          op_b   = {16'd0, sel_s[47:32]};
          op_sub = 1'b1;
          op_sh  = 2'd1;
        end
        3'd5: begin
          op_a    = {16'd0, sel_s[47:32]};
          op_b    = {16'd0, sel_s[47:32]};
          op_sub  = 1'b1;
          op_sh   = 2'd2;
          op_last = 1'b1;
        end
        default: begin
          op_last = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    unique case (pp_sh_r)
      2'd0:    addend = 98'(pp_r);
      2'd1:    addend = {2'b0, pp_r, 32'd0};
      default: addend = {pp_r[33:0], 64'd0};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmh_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_data.operation == bmh_pkg::OP_READ) ? bmh_pkg::S_RD_ISSUE
                                                                : bmh_pkg::S_BIN_DIV;
        end
      end
      bmh_pkg::S_BIN_DIV:   if (cnt_r == 1) state_nxt = bmh_pkg::S_BIN_APPLY;
      bmh_pkg::S_BIN_APPLY: state_nxt = bmh_pkg::S_IDLE;
      bmh_pkg::S_RD_ISSUE:  state_nxt = bmh_pkg::S_RD_WAIT;
      bmh_pkg::S_RD_WAIT: begin
        state_nxt = (rd_hits == 32'd0) ? bmh_pkg::S_DONE : bmh_pkg::S_MEAN_DIV;
      end
      bmh_pkg::S_MEAN_DIV:  if (cnt_r == 1) state_nxt = bmh_pkg::S_MEAN_DONE;
      bmh_pkg::S_MEAN_DONE: state_nxt = bmh_pkg::S_MUL;
      bmh_pkg::S_MUL:       state_nxt = bmh_pkg::S_MUL_ACC;
      bmh_pkg::S_MUL_ACC: begin
        state_nxt = pp_last_r ? bmh_pkg::S_VAR_CHECK : bmh_pkg::S_MUL;
      end
      bmh_pkg::S_VAR_CHECK: begin
        state_nxt = (phase_r == bmh_pkg::PH_FRAC || acc_pos) ? bmh_pkg::S_ERR_DIV
                                                             : bmh_pkg::S_NEXT;
      end
      bmh_pkg::S_ERR_DIV: begin
        if (cnt_r == 1 && pass_r == 2'd2) state_nxt = bmh_pkg::S_SQRT_CHECK;
      end
      bmh_pkg::S_SQRT_CHECK: begin
        state_nxt = (|w_r[DW-1:48]) ? bmh_pkg::S_NEXT : bmh_pkg::S_SQRT;
      end
      bmh_pkg::S_SQRT:      if (cnt_r == 1) state_nxt = bmh_pkg::S_SQRT_DONE;
      bmh_pkg::S_SQRT_DONE: state_nxt = bmh_pkg::S_NEXT;
      bmh_pkg::S_NEXT: begin
        unique case (phase_r)
          bmh_pkg::PH_PER: state_nxt = bmh_pkg::S_MEAN_DIV;
          bmh_pkg::PH_RAD: begin
            state_nxt = (total_r != 32'd0) ? bmh_pkg::S_FR_DIV : bmh_pkg::S_DONE;
          end
          default: state_nxt = bmh_pkg::S_DONE;
        endcase
      end
      bmh_pkg::S_FR_DIV:  if (cnt_r == 1) state_nxt = bmh_pkg::S_FR_DONE;
      bmh_pkg::S_FR_DONE: state_nxt = bmh_pkg::S_MUL;
      bmh_pkg::S_DONE:    if (out_free) state_nxt = bmh_pkg::S_IDLE;
      default:            state_nxt = bmh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == bmh_pkg::S_IDLE) && !store_busy;
    cfg_ready     = 1'b1;
    store_req.rd  = (state_r == bmh_pkg::S_RD_ISSUE) && in_range;
    store_req.acc = (state_r == bmh_pkg::S_BIN_APPLY) && bin_hit;
    store_req.addr = (state_r == bmh_pkg::S_BIN_APPLY) ? bmh_pkg::BIN_AW'(w_r[23:0])
                                                       : bmh_pkg::BIN_AW'(item_r.read_bin);
    store_req.per = item_r.perimeter;
    store_req.rad = item_r.gyration_radius;
    err_we        = 1'b0;
    err_val       = '0;
    unique case (state_r)
      bmh_pkg::S_VAR_CHECK: begin
        err_we = (phase_r != bmh_pkg::PH_FRAC) && !acc_pos;
      end
      bmh_pkg::S_SQRT_CHECK: begin
        err_we  = |w_r[DW-1:48];
        err_val = 24'hFFFFFF;
      end
      bmh_pkg::S_SQRT_DONE: begin
        err_we  = 1'b1;
        err_val = root_r;
      end
      default: begin
        err_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmh_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      bin_width_r <= 24'd1;
      bins_used_r <= 10'd500;
      total_r     <= 32'd0;
      ovf_r       <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bmh_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == bmh_pkg::S_BIN_APPLY && !bin_hit && ovf_r != '1) begin
        ovf_r <= ovf_r + 32'd1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bmh_pkg::CFG_BIN_WIDTH: bin_width_r <= cfg_data[23:0];
          bmh_pkg::CFG_BINS_USED: bins_used_r <= cfg_data[9:0];
          bmh_pkg::CFG_TOTAL:     total_r     <= cfg_data;
          default:                ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      bmh_pkg::S_IDLE: begin
        if (in_fire) begin
          item_r <= in_data;
          w_r    <= {in_data.volume, 88'd0};
          r_r    <= '0;
          d_r    <= 32'(width_eff);
          cnt_r  <= bmh_pkg::CNT_W'(24);
        end
      end
      bmh_pkg::S_BIN_DIV, bmh_pkg::S_MEAN_DIV, bmh_pkg::S_FR_DIV: begin
        w_r   <= {w_r[DW-2:0], div_ge};
        r_r   <= div_rem;
        cnt_r <= cnt_r - 1'b1;
      end
      bmh_pkg::S_RD_WAIT: begin
        hits_r  <= rd_hits;
        bc_r    <= 34'(width_eff) * 34'(item_r.read_bin) + 34'(width_eff[23:1]);
        mp_r    <= '0;
        ep_r    <= '0;
        mr_r    <= '0;
        er_r    <= '0;
        fr_r    <= '0;
        fe_r    <= '0;
        phase_r <= bmh_pkg::PH_PER;
        w_r     <= {rdata.psum, 8'd0, 56'd0};
        r_r     <= '0;
        d_r     <= rd_hits;
        cnt_r   <= bmh_pkg::CNT_W'(56);
      end
      bmh_pkg::S_MEAN_DONE: begin
        if (phase_r == bmh_pkg::PH_PER) begin
          mp_r <= mean_sat;
        end else begin
          mr_r <= mean_sat;
        end
        acc_r <= '0;
        idx_r <= '0;
      end
      bmh_pkg::S_FR_DONE: begin
        fr_r  <= w_r[16:0];
        acc_r <= '0;
        idx_r <= '0;
      end
      bmh_pkg::S_MUL: begin
        pp_r      <= 64'(op_a) * 64'(op_b);
        pp_sub_r  <= op_sub;
        pp_sh_r   <= op_sh;
        pp_last_r <= op_last;
      end
      bmh_pkg::S_MUL_ACC: begin
        acc_r <= pp_sub_r ? (acc_r - $signed(addend)) : (acc_r + $signed(addend));
        idx_r <= idx_r + 1'b1;
      end
      bmh_pkg::S_VAR_CHECK: begin
        if (phase_r == bmh_pkg::PH_FRAC) begin
          w_r <= {16'd0, acc_r[63:0], 32'd0};
          d_r <= total_r;
        end else begin
          w_r <= {acc_r[95:0], 16'd0};
          d_r <= hits_r;
        end
        r_r    <= '0;
        cnt_r  <= bmh_pkg::CNT_W'(DW);
        pass_r <= '0;
      end
      bmh_pkg::S_ERR_DIV: begin
        w_r <= {w_r[DW-2:0], div_ge};
        if (cnt_r == 1) begin
          r_r    <= '0;
          cnt_r  <= bmh_pkg::CNT_W'(DW);
          pass_r <= pass_r + 1'b1;
        end else begin
          r_r   <= div_rem;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      bmh_pkg::S_SQRT_CHECK: begin
        r_r    <= '0;
        root_r <= '0;
        cnt_r  <= bmh_pkg::CNT_W'(24);
      end
      bmh_pkg::S_SQRT: begin
        w_r    <= {w_r[DW-3:0], 2'b00};
        r_r    <= 32'(sq_rem);
        root_r <= {root_r[22:0], sq_ge};
        cnt_r  <= cnt_r - 1'b1;
      end
      bmh_pkg::S_NEXT: begin
        if (phase_r == bmh_pkg::PH_PER) begin
          phase_r <= bmh_pkg::PH_RAD;
          w_r     <= {rdata.rsum, 8'd0, 56'd0};
          r_r     <= '0;
          d_r     <= hits_r;
          cnt_r   <= bmh_pkg::CNT_W'(56);
        end else if (phase_r == bmh_pkg::PH_RAD) begin
          phase_r <= bmh_pkg::PH_FRAC;
          w_r     <= {h_val, 16'd0, 64'd0};
          r_r     <= '0;
          d_r     <= total_r;
          cnt_r   <= bmh_pkg::CNT_W'(48);
        end
      end
      bmh_pkg::S_DONE: begin
        if (out_free) begin
          out_data_r.bin_center      <= bc_r;
          out_data_r.hits            <= hits_r;
          out_data_r.occupied        <= hits_r != 32'd0;
          out_data_r.mean_perimeter  <= mp_r;
          out_data_r.perimeter_error <= ep_r;
          out_data_r.mean_radius     <= mr_r;
          out_data_r.radius_error    <= er_r;
          out_data_r.fraction        <= fr_r;
          out_data_r.fraction_error  <= fe_r;
          out_data_r.overflow_count  <= ovf_r;
        end
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
    if (err_we) begin
      unique case (phase_r)
        bmh_pkg::PH_PER: ep_r <= err_val;
        bmh_pkg::PH_RAD: er_r <= err_val;
        default:         fe_r <= err_val[16:0];
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmh_pkg::S_BIN_DIV || state_r == bmh_pkg::S_MEAN_DIV ||
     state_r == bmh_pkg::S_FR_DIV || state_r == bmh_pkg::S_ERR_DIV) |-> d_r != 32'd0)
    else $error("division by zero");

  a_acc_idle_store: assert property (@(posedge clk) disable iff (!rst_n)
    store_req.acc |-> !store_busy)
    else $error("bin update while store busy");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.occupied) |->
      (out_data_r.mean_perimeter == 24'd0 && out_data_r.fraction == 17'd0))
    else $error("empty bin with nonzero statistics");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.fraction <= 17'h10000)
    else $error("fraction above one");

endmodule
